// File: design/kne_pkg.sv
// Shared types and constants for the keypad number entry block.
`timescale 1ns / 1ps

package kne_pkg;

    // What one scan sample stands for.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DIGIT  = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_ENTER  = 2'd3
    } t_key_kind;

    typedef struct packed {
        t_key_kind  kind;
        logic [3:0] digit;
    } t_key;

    localparam int COL_WIDTH   = 3;
    localparam int ROW_WIDTH   = 4;
    localparam int VALUE_OUT_W = 10;
    localparam int COUNT_OUT_W = 2;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    localparam int DECIMAL_BASE = 10;

    // Divide by ten: floor(v * DIV10_MULT / 2**DIV10_SHIFT) is exact for v below 2**30.
    localparam int          DIV10_SHIFT = 33;
    localparam logic [29:0] DIV10_MULT  = 30'd858993460;

endpackage

// File: design/kne_key_decode.sv
// Keypad scan sample decoder: active-low row and column lines to a key.
`timescale 1ns / 1ps

module kne_key_decode
    import kne_pkg::*;
(
    input  logic [COL_WIDTH-1:0] i_column_lines,
    input  logic [ROW_WIDTH-1:0] i_row_lines,
    output t_key                 o_key
);

    logic [1:0] w_col;   // 1..3, 0 for none
    logic [2:0] w_row;   // 1..4, 0 for none

    // Lowest-numbered active line wins in each group.
    always_comb begin
        priority if (!i_column_lines[0]) w_col = 2'd3;
        else if (!i_column_lines[1])     w_col = 2'd2;
        else if (!i_column_lines[2])     w_col = 2'd1;
        else                             w_col = 2'd0;
    end

    always_comb begin
        priority if (!i_row_lines[0]) w_row = 3'd4;
        else if (!i_row_lines[1])     w_row = 3'd3;
        else if (!i_row_lines[2])     w_row = 3'd2;
        else if (!i_row_lines[3])     w_row = 3'd1;
        else                          w_row = 3'd0;
    end

    always_comb begin
        o_key.kind  = KIND_NONE;
        o_key.digit = 4'd0;
        if (w_row != 3'd0 && w_col != 2'd0) begin
            if (w_row == 3'd4) begin
                unique case (w_col)
                    2'd1:    o_key.kind = KIND_DELETE;
                    2'd2:    o_key.kind = KIND_DIGIT;
                    default: o_key.kind = KIND_ENTER;
                endcase
            end else begin
                // rows 1..3 hold digits (row - 1) * 3 + column
                o_key.kind  = KIND_DIGIT;
                o_key.digit = 4'((w_row - 3'd1) * 3'd3) + 4'(w_col);
            end
        end
    end

endmodule

// File: design/kne_entry.sv
// Number entry state: held-key tracking, decimal accumulate, delete and emit.
`timescale 1ns / 1ps

module kne_entry
    import kne_pkg::*;
#(
    parameter int MAX_DIGITS = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  t_key                   i_key,
    output logic                   o_emit,
    output logic [VALUE_OUT_W-1:0] o_entered_value,
    output logic [COUNT_OUT_W-1:0] o_digit_count
);

    localparam int VW = $clog2(10 ** MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [VW-1:0] r_value, n_value;
    logic [CW-1:0] r_digits, n_digits;
    logic          r_held, n_held;

    logic [VW-1:0]    w_appended;
    logic [CW-1:0]    w_digits_inc;
    logic [VW+29:0]   w_div_prod;
    logic [VW-1:0]    w_div10;
    logic [VW-1:0]    w_res_value;
    logic [CW-1:0]    w_res_digits;
    logic [VW+9:0]    w_value_ext;
    logic [CW+1:0]    w_count_ext;

    assign w_appended   = VW'(r_value * VW'(DECIMAL_BASE) + VW'(i_key.digit));
    assign w_digits_inc = r_digits + CW'(1);
    assign w_div_prod   = (VW + 30)'(r_value) * (VW + 30)'(DIV10_MULT);
    assign w_div10      = VW'(w_div_prod >> DIV10_SHIFT);

    always_comb begin
        n_value      = r_value;
        n_digits     = r_digits;
        n_held       = r_held;
        o_emit       = 1'b0;
        w_res_value  = r_value;
        w_res_digits = r_digits;
        if (i_go) begin
            unique case (i_key.kind)
                KIND_NONE: n_held = 1'b0;
                KIND_ENTER: begin
                    if (!r_held) begin
                        n_held   = 1'b1;
                        o_emit   = 1'b1;
                        n_value  = '0;
                        n_digits = '0;
                    end
                end
                KIND_DELETE: begin
                    if (!r_held) begin
                        n_held  = 1'b1;
                        n_value = w_div10;
                        if (r_digits != '0) n_digits = r_digits - CW'(1);
                    end
                end
                KIND_DIGIT: begin
                    if (!r_held) begin
                        n_held       = 1'b1;
                        w_res_value  = w_appended;
                        w_res_digits = w_digits_inc;
                        if (w_digits_inc >= CW'(MAX_DIGITS)) begin
                            o_emit   = 1'b1;
                            n_value  = '0;
                            n_digits = '0;
                        end else begin
                            n_value  = w_appended;
                            n_digits = w_digits_inc;
                        end
                    end
                end
                default: n_held = r_held;
            endcase
        end
    end

    // Mask the result to the output field widths.
    assign w_value_ext     = (VW + 10)'(w_res_value);
    assign w_count_ext     = (CW + 2)'(w_res_digits);
    assign o_entered_value = w_value_ext[VALUE_OUT_W-1:0];
    assign o_digit_count   = w_count_ext[COUNT_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= '0;
            r_digits <= '0;
            r_held   <= 1'b0;
        end else begin
            r_value  <= n_value;
            r_digits <= n_digits;
            r_held   <= n_held;
        end
    end

endmodule

// File: design/keypad_number_entry.sv
// Top level: numeric entry from 4x3 matrix keypad scan samples over stream ports.
// A transferred sample is held in the input stage, then decoded and applied once the result
//   stage is free or draining; its result (if any) is registered there for the master port.
// Throughput: one sample per cycle unless the master port stalls the result stage.
// Reset (synchronous, i_rst_n low): empty entry, no key held, both stages empty.
`timescale 1ns / 1ps

module keypad_number_entry
    import kne_pkg::*;
#(
    parameter int MAX_DIGITS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // s_axis: [2:0] column_lines, [6:3] row_lines, [7] zero
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // m_axis: [9:0] entered_value, [11:10] digit_count, [15:12] zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    // Input stage: holds one sample until the result side can take it.
    logic                 r_in_valid;
    logic [COL_WIDTH-1:0] r_column_lines;
    logic [ROW_WIDTH-1:0] r_row_lines;

    // Result stage.
    logic                   r_out_valid;
    logic [VALUE_OUT_W-1:0] r_entered_value;
    logic [COUNT_OUT_W-1:0] r_digit_count;

    logic                   w_go;
    t_key                   w_key;
    logic                   w_emit;
    logic [VALUE_OUT_W-1:0] w_entered_value;
    logic [COUNT_OUT_W-1:0] w_digit_count;

    // Apply the held sample whenever the result register is free or being drained.
    assign w_go          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;

    kne_key_decode u_decode (
        .i_column_lines (r_column_lines),
        .i_row_lines    (r_row_lines),
        .o_key          (w_key)
    );

    kne_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (w_go),
        .i_key           (w_key),
        .o_emit          (w_emit),
        .o_entered_value (w_entered_value),
        .o_digit_count   (w_digit_count)
    );

    // Capture a new sample on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_column_lines <= s_axis_tdata[COL_WIDTH-1:0];
            r_row_lines    <= s_axis_tdata[COL_WIDTH+ROW_WIDTH-1:COL_WIDTH];
        end
    end

    // Load the result register when a sample is applied; drop it once transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_entered_value <= w_entered_value;
            r_digit_count   <= w_digit_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - VALUE_OUT_W - COUNT_OUT_W){1'b0}},
                            r_digit_count, r_entered_value};

endmodule

// File: bench/keypad_number_entry_test.sv
// Self-checking testbench for keypad_number_entry: scan-sample stimulus, predicted entries.
`timescale 1ns / 1ps

module keypad_number_entry_test;
    import kne_pkg::*;

    localparam int ENTRY_DIGITS = 3;
    localparam int IDLE_PCT     = 27;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam t_key KEY_DEL = '{kind: KIND_DELETE, digit: 4'd0};
    localparam t_key KEY_ENT = '{kind: KIND_ENTER, digit: 4'd0};

    // Released keypad: every line high.
    localparam logic [6:0] LINES_IDLE = 7'h7F;

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value;
        logic [COUNT_OUT_W-1:0] count;
    } t_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // Entry state as the block should hold it.
    int unsigned entry_value  = 0;
    int unsigned entry_digits = 0;
    bit          key_down     = 1'b0;

    t_entry entries_due[$];

    bit steady = 1'b0;
    int samples_sent    = 0;
    int presses_taken   = 0;
    int entries_checked = 0;
    int fail_count      = 0;
    int quiet_cycles    = 0;

    keypad_number_entry #(
        .MAX_DIGITS(ENTRY_DIGITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Lowest active line of each group wins; no column or no row means no key.
    function automatic t_key decode_sample(input logic [2:0] col, input logic [3:0] row);
        t_key k;
        int   c;
        int   r;
        c = !col[0] ? 3 : !col[1] ? 2 : !col[2] ? 1 : 0;
        r = !row[0] ? 4 : !row[1] ? 3 : !row[2] ? 2 : !row[3] ? 1 : 0;
        k.digit = 4'd0;
        if (r == 0 || c == 0) begin
            k.kind = KIND_NONE;
        end else if (r <= 3) begin
            k.kind  = KIND_DIGIT;
            k.digit = 4'((r - 1) * 3 + c);
        end else if (c == 1) begin
            k.kind = KIND_DELETE;
        end else if (c == 2) begin
            k.kind = KIND_DIGIT;
        end else begin
            k.kind = KIND_ENTER;
        end
        return k;
    endfunction

    // Advance the predicted entry by one accepted sample; queue a finished number.
    function automatic void apply_sample(input logic [6:0] lines);
        t_key k;
        bit   done;
        k    = decode_sample(lines[2:0], lines[6:3]);
        done = 1'b0;
        if (k.kind == KIND_NONE) begin
            key_down = 1'b0;
            return;
        end
        if (key_down)
            return;
        key_down = 1'b1;
        presses_taken++;
        case (k.kind)
            KIND_ENTER: begin
                done = 1'b1;
            end
            KIND_DELETE: begin
                entry_value = entry_value / DECIMAL_BASE;
                if (entry_digits > 0)
                    entry_digits--;
            end
            default: begin
                entry_value = entry_value * DECIMAL_BASE + k.digit;
                entry_digits++;
                if (entry_digits >= ENTRY_DIGITS)
                    done = 1'b1;
            end
        endcase
        if (done) begin
            entries_due.push_back({entry_value[VALUE_OUT_W-1:0],
                                   entry_digits[COUNT_OUT_W-1:0]});
            entry_value  = 0;
            entry_digits = 0;
        end
    endfunction

    function automatic t_key digit_key(input int d);
        t_key k;
        k.kind  = KIND_DIGIT;
        k.digit = 4'(d);
        return k;
    endfunction

    // Lines for a key; with spread, lower-priority lines are random as well.
    function automatic logic [6:0] key_lines(input t_key k, input bit spread);
        int         r;
        int         c;
        logic [2:0] col;
        logic [3:0] row;
        if (k.kind == KIND_DIGIT && k.digit != 0) begin
            r = (k.digit - 1) / 3 + 1;
            c = (k.digit - 1) % 3 + 1;
        end else begin
            r = 4;
            c = (k.kind == KIND_DELETE) ? 1 : (k.kind == KIND_ENTER) ? 3 : 2;
        end
        col = spread ? 3'($urandom) : 3'b111;
        row = spread ? 4'($urandom) : 4'b1111;
        col = col | 3'((1 << (3 - c)) - 1);
        row = row | 4'((1 << (4 - r)) - 1);
        col[3 - c] = 1'b0;
        row[4 - r] = 1'b0;
        return {row, col};
    endfunction

    // A no-key sample: no column line, no row line, or neither.
    function automatic logic [6:0] release_lines();
        case ($urandom_range(2))
            0:       return LINES_IDLE;
            1:       return {4'($urandom), 3'b111};
            default: return {4'b1111, 3'($urandom)};
        endcase
    endfunction

    // Offer one scan sample and hold it until the block takes it.
    task automatic send_sample(input logic [6:0] lines);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lines};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        samples_sent++;
        apply_sample(lines);
    endtask

    task automatic tap(input t_key k);
        send_sample(key_lines(k, 1'b0));
        send_sample(LINES_IDLE);
    endtask

    // Enter on an empty entry emits zero with no digits; delete there does nothing.
    task automatic test_empty_entry();
        tap(KEY_ENT);
        tap(KEY_DEL);
    endtask

    // 9, 8, delete, 7, 0: the 0 makes three digits and completes 970.
    task automatic test_digits_and_delete();
        tap(digit_key(9));
        tap(digit_key(8));
        tap(KEY_DEL);
        tap(digit_key(7));
        tap(digit_key(0));
    endtask

    // A second key while 4 is still down must be dropped.
    task automatic test_held_key();
        send_sample(key_lines(digit_key(4), 1'b0));
        send_sample(key_lines(digit_key(1), 1'b0));
        send_sample(LINES_IDLE);
        tap(digit_key(5));
        tap(digit_key(6));
    endtask

    // Several columns low at once; release by dropping all columns, then all rows.
    task automatic test_line_priority();
        send_sample({4'b0111, 3'b011});
        send_sample({4'b0000, 3'b111});
        send_sample({4'b0111, 3'b001});
        send_sample({4'b1111, 3'b000});
        send_sample({4'b0111, 3'b000});
        send_sample(LINES_IDLE);
    endtask

    // Mostly well-formed press/release sequences with random extra lines, some
    // held presses with other keys, some presses that are never released.
    task automatic test_random_entry(input int n_items);
        int   sent;
        int   roll;
        int   holds;
        t_key k;
        sent   = 0;
        steady = 1'b1;
        while (sent < n_items) begin
            if (sent >= 300)
                steady = 1'b0;
            roll = $urandom_range(99);
            if (roll < 70)
                k = digit_key($urandom_range(9));
            else if (roll < 82)
                k = KEY_DEL;
            else
                k = KEY_ENT;
            send_sample(key_lines(k, 1'b1));
            sent++;
            holds = $urandom_range(2);
            repeat (holds) begin
                if ($urandom_range(99) < 30)
                    send_sample(key_lines(digit_key($urandom_range(9)), 1'b1));
                else
                    send_sample(key_lines(k, 1'b1));
                sent++;
            end
            if ($urandom_range(99) >= 10) begin
                repeat ($urandom_range(1, 2)) begin
                    send_sample(release_lines());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_noise(input int n_items);
        repeat (n_items)
            send_sample(7'($urandom));
    endtask

    // Receiver back-pressure; none during the steady stretch.
    always @(posedge i_clk)
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Compare each transferred entry with the oldest prediction.
    always @(posedge i_clk) begin : entry_check
        t_entry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (entries_due.size() == 0) begin
                $error("unexpected entry: value %0d count %0d",
                       m_axis_tdata[VALUE_OUT_W-1:0],
                       m_axis_tdata[VALUE_OUT_W+COUNT_OUT_W-1:VALUE_OUT_W]);
                fail_count++;
            end else begin
                want = entries_due.pop_front();
                entries_checked++;
                if (m_axis_tdata[VALUE_OUT_W-1:0] !== want.value) begin
                    $error("entered_value: expected %0d, got %0d", want.value,
                           m_axis_tdata[VALUE_OUT_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[VALUE_OUT_W+COUNT_OUT_W-1:VALUE_OUT_W] !== want.count) begin
                    $error("digit_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[VALUE_OUT_W+COUNT_OUT_W-1:VALUE_OUT_W]);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run: too long without a transfer on either port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("keypad_number_entry_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_entry();
        test_digits_and_delete();
        test_held_key();
        test_line_priority();
        test_random_entry(900);
        test_random_noise(250);

        s_axis_tvalid <= 1'b0;
        while (entries_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (entries_due.size() != 0) begin
            $error("%0d predicted entries never arrived", entries_due.size());
            fail_count++;
        end
        $display("Covered %0d scan samples with %0d accepted key presses;", samples_sent,
                 presses_taken);
        $display("%0d entered numbers compared against the prediction.", entries_checked);
        if (fail_count == 0)
            $display("keypad_number_entry_test OK");
        else
            $display("keypad_number_entry_test NOT OK");
        $finish;
    end

endmodule
